// ----- rtl/core/rpn_pkg.sv -----
package rpn_pkg;

  localparam int STACK_DEPTH_DEF = 64;

  // operation codes
  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_DIVZERO   = 2'd3;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // what a stack cell loads this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_UP,
    CELL_TAKE_DOWN
  } cell_mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_EMIT
  } state_t;

  // clamp a 48-bit signed value into Q16.16
  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    logic fits;
    begin
      fits = (v[47:31] == 17'h0) || (v[47:31] == 17'h1FFFF);
      if (fits) begin
        sat48 = v[31:0];
      end else if (v[47]) begin
        sat48 = Q_MIN;
      end else begin
        sat48 = Q_MAX;
      end
    end
  endfunction

endpackage

// ----- rtl/core/rpn_stack_calculator.sv -----
// Channel  Dir  tdata fields (low bit up)                          Width
// s_*      in   operation[2:0], push_value[34:3], zero pad          40
// m_*      out  top_value[31:0], depth[38:32], status[40:39], pad   48
//
// Push, add, subtract, unused codes and errors: accept, then emit.
// Multiply: accept, multiply state, emit; product registered before the shift and clamp.
// Divide: waits in the divide state for the bit-serial divider (32 iterations).
// Sync reset clears the entry count, FSM and output valid; cell contents stay.
// A new item is taken while an earlier result still waits in the output
// register; it then holds in the emit state until that transfer completes.
module rpn_stack_calculator
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // operation[2:0], push_value[34:3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // top_value[31:0], depth[38:32], status[40:39]
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  // input fields
  logic [2:0]         operation;
  logic signed [31:0] push_value;
  assign operation  = s_tdata[2:0];
  assign push_value = $signed(s_tdata[34:3]);

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [1:0]    status, status_next;
  logic signed [63:0] product;

  // stack row: cell 0 is the top (S), cell 1 below it (T)
  logic signed [31:0] cell_q [STACK_DEPTH];
  cell_mode_t         mode_top, mode_rest;
  logic signed [31:0] head_value;

  logic accept;
  logic out_load;
  logic div_start;
  logic div_done;
  logic signed [31:0] div_q;

  logic signed [31:0] s_val, t_val;
  logic signed [32:0] sum;
  logic signed [31:0] addsub_res;
  logic signed [63:0] mul_full;
  logic signed [63:0] prod_adj;
  logic signed [31:0] mul_res;
  logic               full;
  logic               short;

  assign s_val = cell_q[0];
  assign t_val = cell_q[1];

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_top
        rpn_cell u_cell (
          .clk        (clk),
          .mode       (mode_top),
          .up_value   (head_value),
          .down_value (cell_q[1]),
          .value      (cell_q[0])
        );
      end else if (gi == STACK_DEPTH - 1) begin : g_bottom
        rpn_cell u_cell (
          .clk        (clk),
          .mode       (mode_rest),
          .up_value   (cell_q[gi-1]),
          .down_value (32'sd0),
          .value      (cell_q[gi])
        );
      end else begin : g_mid
        rpn_cell u_cell (
          .clk        (clk),
          .mode       (mode_rest),
          .up_value   (cell_q[gi-1]),
          .down_value (cell_q[gi+1]),
          .value      (cell_q[gi])
        );
      end
    end
  endgenerate

  rpn_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (t_val),
    .divisor  (s_val),
    .done     (div_done),
    .quotient (div_q)
  );

  // add / subtract, clamped
  assign sum = (operation == OP_SUB) ? ({t_val[31], t_val} - {s_val[31], s_val})
                                     : ({t_val[31], t_val} + {s_val[31], s_val});
  assign addsub_res = sat48({{15{sum[32]}}, sum});

  // multiply: full product, then /2^16 toward zero and clamp
  assign mul_full = t_val * s_val;
  assign prod_adj = product + (product[63] ? 64'sd65535 : 64'sd0);
  assign mul_res  = sat48(prod_adj[63:16]);

  assign full   = (count >= CW'(STACK_DEPTH));
  assign short  = (count < CW'(2));
  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      status <= STAT_OK;
    end else begin
      state  <= state_next;
      count  <= count_next;
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      product <= mul_full;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    status_next = status;
    mode_top    = CELL_HOLD;
    mode_rest   = CELL_HOLD;
    head_value  = push_value;
    div_start   = 1'b0;
    out_load    = 1'b0;
    s_tready    = (state == S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next  = S_EMIT;
          status_next = STAT_OK;
          priority if (operation == OP_PUSH) begin
            if (full) begin
              status_next = STAT_FULL;
            end else begin
              mode_top   = CELL_TAKE_UP;
              mode_rest  = CELL_TAKE_UP;
              count_next = count + CW'(1);
            end
          end else if (operation > OP_DIV) begin
            status_next = STAT_OK;
          end else if (short) begin
            status_next = STAT_UNDERFLOW;
          end else if (operation == OP_ADD || operation == OP_SUB) begin
            head_value = addsub_res;
            mode_top   = CELL_TAKE_UP;
            mode_rest  = CELL_TAKE_DOWN;
            count_next = count - CW'(1);
          end else if (operation == OP_MUL) begin
            state_next = S_MUL;
          end else begin
            if (s_val == 32'sd0) begin
              status_next = STAT_DIVZERO;
            end else begin
              div_start  = 1'b1;
              state_next = S_DIV;
            end
          end
        end
      end
      S_MUL: begin
        head_value = mul_res;
        mode_top   = CELL_TAKE_UP;
        mode_rest  = CELL_TAKE_DOWN;
        count_next = count - CW'(1);
        state_next = S_EMIT;
      end
      S_DIV: begin
        if (div_done) begin
          head_value = div_q;
          mode_top   = CELL_TAKE_UP;
          mode_rest  = CELL_TAKE_DOWN;
          count_next = count - CW'(1);
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output register, parts the two sides
  logic [CW+6:0]      count_ext;
  logic signed [31:0] top_value;
  assign count_ext = {7'h0, count};
  assign top_value = (count != '0) ? cell_q[0] : 32'sd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'h0, status, count_ext[6:0], top_value};
    end
  end

endmodule

// ----- rtl/core/rpn_cell.sv -----
// one stack entry; loads from its upper or lower neighbour
module rpn_cell
  import rpn_pkg::*;
(
  input  logic              clk,
  input  cell_mode_t        mode,
  input  logic signed [31:0] up_value,
  input  logic signed [31:0] down_value,
  output logic signed [31:0] value
);

  always_ff @(posedge clk) begin
    unique case (mode)
      CELL_HOLD:      value <= value;
      CELL_TAKE_UP:   value <= up_value;
      CELL_TAKE_DOWN: value <= down_value;
      default:        value <= value;
    endcase
  end

endmodule

// ----- rtl/core/rpn_divider.sv -----
// signed Q16.16 divide, restoring, one quotient bit per cycle
module rpn_divider
  import rpn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic signed [31:0] divisor,
  output logic               done,
  output logic signed [31:0] quotient
);

  logic        run;
  logic        fin;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] src;
  logic [31:0] q;
  logic [31:0] dvs;
  logic        neg;
  logic        ovf;

  logic [31:0] mag_n;
  logic [31:0] mag_d;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        ge;

  assign mag_n  = dividend[31] ? 32'(-dividend) : 32'(dividend);
  assign mag_d  = divisor[31]  ? 32'(-divisor)  : 32'(divisor);
  assign rem_sh = {rem, src[31]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign ge     = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
      fin <= 1'b0;
    end else if (run) begin
      if (cnt == 5'd31) begin
        run <= 1'b0;
        fin <= 1'b1;
      end
    end else begin
      fin <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= 5'd0;
      dvs <= mag_d;
      rem <= {16'h0, mag_n[31:16]};
      src <= {mag_n[15:0], 16'h0};
      q   <= 32'h0;
      neg <= dividend[31] ^ divisor[31];
      // quotient needs more than 32 bits
      ovf <= ({16'h0, mag_n[31:16]} >= mag_d);
    end else if (run) begin
      cnt <= cnt + 5'd1;
      rem <= ge ? diff[31:0] : rem_sh[31:0];
      src <= {src[30:0], 1'b0};
      q   <= {q[30:0], ge};
    end
  end

  assign done = fin;

  always_comb begin
    if (ovf) begin
      quotient = neg ? Q_MIN : Q_MAX;
    end else if (neg) begin
      quotient = (q > 32'h8000_0000) ? Q_MIN : $signed(32'(-q));
    end else begin
      quotient = q[31] ? Q_MAX : $signed(q);
    end
  end

endmodule

// ----- bench/rpn_stack_calculator_checker.sv -----
module rpn_stack_calculator_checker
  import rpn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // operation[2:0], push_value[34:3]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // top_value[31:0], depth[38:32], status[40:39]
  output int          fail_count,
  output int          awaiting,
  output int          results_seen,
  output int          hits_underflow,
  output int          hits_full,
  output int          hits_divzero,
  output int          hits_clamped
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [6:0]         depth;
    logic [1:0]         status;
  } calc_result_t;

  // shadow of the stack
  logic signed [31:0] stack_cells [STACK_DEPTH_DEF];
  logic [6:0]         stack_count;

  calc_result_t expected_results [$];

  initial begin
    fail_count     = 0;
    awaiting       = 0;
    results_seen   = 0;
    hits_underflow = 0;
    hits_full      = 0;
    hits_divzero   = 0;
    hits_clamped   = 0;
    stack_count    = '0;
  end

  function automatic logic signed [31:0] clamp_q(input longint v);
    if (v > longint'(Q_MAX)) begin
      return Q_MAX;
    end
    if (v < longint'(Q_MIN)) begin
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  // one calculator step on the shadow stack; lower is the top entry, upper the one below
  function automatic calc_result_t apply_item(input logic [2:0] op,
                                              input logic signed [31:0] value);
    calc_result_t r;
    longint       upper;
    longint       lower;
    longint       wide;
    logic [1:0]   code;
    code = STAT_OK;
    wide = 0;
    if (op == OP_PUSH) begin
      if (stack_count >= STACK_DEPTH_DEF) begin
        code = STAT_FULL;
      end else begin
        stack_cells[stack_count] = value;
        stack_count++;
      end
    end else if (op <= OP_DIV) begin
      if (stack_count < 2) begin
        code = STAT_UNDERFLOW;
      end else begin
        lower = stack_cells[stack_count - 1];
        upper = stack_cells[stack_count - 2];
        case (op)
          OP_ADD: begin
            wide = upper + lower;
          end
          OP_SUB: begin
            wide = upper - lower;
          end
          OP_MUL: begin
            wide = (upper * lower) / 65536;
          end
          default: begin
            if (lower == 0) begin
              code = STAT_DIVZERO;
            end else begin
              wide = (upper * 65536) / lower;
            end
          end
        endcase
        if (code == STAT_OK) begin
          stack_count--;
          stack_cells[stack_count - 1] = clamp_q(wide);
          if (longint'(clamp_q(wide)) != wide) begin
            hits_clamped++;
          end
        end
      end
    end
    case (code)
      STAT_UNDERFLOW: hits_underflow++;
      STAT_FULL:      hits_full++;
      STAT_DIVZERO:   hits_divzero++;
      default: ;
    endcase
    r.top_value = (stack_count == 0) ? '0 : stack_cells[stack_count - 1];
    r.depth     = stack_count;
    r.status    = code;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    calc_result_t got;
    calc_result_t want;
    if (rst) begin
      stack_count = '0;
      expected_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_item(s_tdata[2:0], s_tdata[34:3]));
      end
      if (m_tvalid && m_tready) begin
        got.top_value = m_tdata[31:0];
        got.depth     = m_tdata[38:32];
        got.status    = m_tdata[40:39];
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: top_value %0d depth %0d status %0d",
                 got.top_value, got.depth, got.status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.top_value !== want.top_value) begin
            $error("top_value: expected %0d, got %0d", want.top_value, got.top_value);
            fail_count++;
          end
          if (got.depth !== want.depth) begin
            $error("depth: expected %0d, got %0d", want.depth, got.depth);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
        end
      end
    end
    awaiting = expected_results.size();
  end

endmodule

// ----- bench/rpn_stack_calculator_test.sv -----
module rpn_stack_calculator_test
  import rpn_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // codes the block must ignore
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID   = 3'd6;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  localparam int TOTAL_ITEMS   = 1350;
  localparam int HOLD_AT_ITEM  = 400;   // long receiver hold-off starts here
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;  // cycles without any transfer
  localparam int SETTLE_CYCLES = 60;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // operation[2:0], push_value[34:3]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // top_value[31:0], depth[38:32], status[40:39]

  int fail_count;
  int awaiting;
  int results_seen;
  int hits_underflow;
  int hits_full;
  int hits_divzero;
  int hits_clamped;

  int items_sent = 0;
  int burst_left = 0;

  rpn_stack_calculator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  rpn_stack_calculator_checker result_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .fail_count     (fail_count),
    .awaiting       (awaiting),
    .results_seen   (results_seen),
    .hits_underflow (hits_underflow),
    .hits_full      (hits_full),
    .hits_divzero   (hits_divzero),
    .hits_clamped   (hits_clamped)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one item from a falling edge and hold it until the transfer.
  // Afterwards either carry on with the burst (valid stays high) or drop
  // valid for a random gap with junk on tdata.
  task automatic offer_item(input logic [2:0] op, input logic [31:0] value);
    s_tdata  <= {5'b0, value, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      s_tdata  <= 40'({$urandom, $urandom});
      repeat ($urandom_range(1, 8)) @(negedge clk);
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                              : $urandom_range(0, 24);
    end
  endtask

  // Push values: full-range noise in 4 of 10 cases, with a good share of small and
  // integer values so products and quotients stay meaningful, plus zeros
  // for divide by zero and the range ends for clamping.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      7:          v = '0;
      8: begin
        case ($urandom_range(0, 5))
          0:       v = Q_MAX;
          1:       v = Q_MIN;
          2:       v = 32'h0000_0001;
          3:       v = 32'hFFFF_FFFF;
          4:       v = 32'h0001_0000;
          default: v = 32'hFFFF_0000;
        endcase
      end
      default: begin
        v = {8'h0, 8'($urandom_range(0, 255)), 16'h0};
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  function automatic logic [2:0] pick_arith();
    return 3'($urandom_range(OP_ADD, OP_DIV));
  endfunction

  // -------------------------------------------------------------------
  // Stimulus and verdict
  // -------------------------------------------------------------------
  initial begin : stimulus
    int seg_kind;
    int seg_len;
    int pick;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed part; stack contents noted bottom to top.
    offer_item(OP_ADD, '0);                  // empty: underflow
    offer_item(OP_DIV, '0);                  // empty: underflow
    offer_item(OP_UNUSED_FIRST, '1);         // ignored, reports empty
    offer_item(OP_PUSH, '0);                 // [0]
    offer_item(OP_DIV, '0);                  // one entry, zero on top: underflow wins
    offer_item(OP_PUSH, Q_MAX);              // [0 max]
    offer_item(OP_PUSH, Q_MAX);              // [0 max max]
    offer_item(OP_ADD, '0);                  // clamps high: [0 max]
    offer_item(OP_PUSH, Q_MIN);              // [0 max min]
    offer_item(OP_SUB, '0);                  // max - min clamps high
    offer_item(OP_PUSH, '0);                 // [0 max 0]
    offer_item(OP_DIV, '0);                  // divide by zero, stack kept
    offer_item(OP_UNUSED_MID, 32'h1234_5678); // ignored
    offer_item(OP_MUL, '0);                  // max * 0: [0 0]
    offer_item(OP_PUSH, Q_MIN);              // [0 0 min]
    offer_item(OP_PUSH, 32'hFFFF_FFFF);      // smallest negative step
    offer_item(OP_DIV, '0);                  // min / -ulp clamps high
    offer_item(OP_PUSH, Q_MIN);
    offer_item(OP_MUL, '0);                  // max * min clamps low
    offer_item(OP_PUSH, 32'h0003_0000);      // 3.0
    offer_item(OP_DIV, '0);                  // min / 3, truncated toward zero
    offer_item(OP_PUSH, Q_MAX);
    offer_item(OP_SUB, '0);                  // clamps low
    offer_item(OP_UNUSED_LAST, '0);          // ignored, stack reported as is

    // Random part in segments: mixed traffic, drains that run into
    // underflow, and fills that reach the full stack and push past it.
    while (items_sent < TOTAL_ITEMS) begin
      seg_kind = $urandom_range(0, 9);
      if (seg_kind <= 5) begin
        seg_len = $urandom_range(10, 40);
      end else if (seg_kind <= 7) begin
        seg_len = $urandom_range(20, 70);
      end else begin
        seg_len = $urandom_range(60, 75);
      end
      repeat (seg_len) begin
        pick = $urandom_range(0, 99);
        if (seg_kind <= 5) begin
          if (pick < 48) begin
            offer_item(OP_PUSH, pick_value());
          end else if (pick < 96) begin
            offer_item(pick_arith(), $urandom);
          end else begin
            offer_item(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), $urandom);
          end
        end else if (seg_kind <= 7) begin
          if (pick < 15) begin
            offer_item(OP_PUSH, pick_value());
          end else if (pick < 97) begin
            offer_item(pick_arith(), $urandom);
          end else begin
            offer_item(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), $urandom);
          end
        end else begin
          if (pick < 92) begin
            offer_item(OP_PUSH, pick_value());
          end else begin
            offer_item(pick_arith(), $urandom);
          end
        end
      end
    end

    // offer_item may have left valid high for a burst; this edge had no
    // other assignment to it
    s_tvalid <= 1'b0;

    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items in, %0d results compared, %0d clamped",
             items_sent, results_seen, hits_clamped);
    $display("error cases: %0d underflow, %0d full stack, %0d divide by zero",
             hits_underflow, hits_full, hits_divzero);
    if (fail_count == 0 && awaiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // -------------------------------------------------------------------
  // Receiver: stall pattern of its own, changing mode every span, with
  // one long hold-off mid-run so the output register and the emit stage
  // fill and s_tready drops while items are still on offer.
  // -------------------------------------------------------------------
  initial begin : result_drain
    int  mode;
    int  span;
    bit  hold_done;
    hold_done = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 120);
        repeat (span) begin
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 9) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  // Watchdog: no transfer on either side for too long ends the run.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
